// File: hdl/triangle_plane_slice_core_assert.svh
// Assertion macros for the checker of the plane slicer.
`ifndef TRIANGLE_PLANE_SLICE_CORE_ASSERT_SVH
`define TRIANGLE_PLANE_SLICE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tps_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned DiffW    = 33;
  localparam int unsigned TermW    = 40;
  localparam int unsigned DistW    = 43;
  localparam int unsigned SumW     = 33;
  localparam int unsigned ShMax    = DistW - SumW;
  localparam int unsigned QuoW     = 31;
  localparam int unsigned DivSteps = 30;
  localparam int unsigned NumCand  = 6;
  localparam int unsigned DupLimit = 28148;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  localparam logic signed [CoordW-1:0] NormalZReset = 32'sd16777216;
  localparam logic [15:0]              LimitReset   = 16'd17;
  localparam logic signed [DiffW-1:0]  Nudge        = 33'sd1678;

  // Pipeline stage numbers; the result register is the last stage.
  localparam int unsigned StDif     = 1;
  localparam int unsigned StMul     = 2;
  localparam int unsigned StDst     = 3;
  localparam int unsigned StCls     = 4;
  localparam int unsigned StNrm     = 5;
  localparam int unsigned StDiv0    = 6;
  localparam int unsigned StDivN    = StDiv0 + DivSteps;
  localparam int unsigned StLrm     = StDivN + 1;
  localparam int unsigned StCnd     = StLrm + 1;
  localparam int unsigned StDdf     = StCnd + 1;
  localparam int unsigned StNear    = StDdf + 1;
  localparam int unsigned PipeDepth = StNear + 1;

  typedef enum logic [2:0] {
    RegOriginX,
    RegOriginY,
    RegOriginZ,
    RegNormalX,
    RegNormalY,
    RegNormalZ,
    RegTag,
    RegLimit
  } tps_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] c_z;
  } tps_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
    logic [7:0]               tag_out;
  } tps_result_t;

  typedef struct packed {
    logic       miss;
    logic [2:0] on;
    logic [2:0] xing;
  } tps_ctl_t;

endpackage
`default_nettype wire

// File: hdl/triangle_plane_slice_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Slices one triangle per beat against a plane held in configuration registers.
// Configuration: APB-style port, register i at byte address 4*i, to be written
// by the user only while no triangle is in flight; the block does not enforce
// this. pready is always high; reads return the value.
// Input: a beat is taken on each rising edge with start high and busy low. busy
// is always low, so a new triangle may enter on every cycle.
// Output: done_o is high for exactly one cycle with the segment on res_o.
// Throughput is one triangle per cycle. The crossing fraction is found by a
// restoring divider laid out as 31 pipeline stages of one quotient bit each;
// the other stages form the differences, the distance products and sums, the
// classification, the shift, the interpolation and the duplicate test.
// The receiver cannot hold results off and needs not to: the pipeline never
// stalls. Reset loads the register defaults and drops every triangle in flight.
module triangle_plane_slice_core
  import tps_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire tps_item_t         item_i,
  output logic                   done_o,
  output tps_result_t            res_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]       prdata,
  output logic                   pready
);

  // Configuration registers.
  logic signed [CoordW-1:0] org_q [3];
  logic signed [CoordW-1:0] nrm_q [3];
  logic [7:0]               tag_q;
  logic [15:0]              lim_q;
  tps_reg_e                 reg_sel;
  logic                     wr_en;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_sel = tps_reg_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      nrm_q[0] <= '0;
      nrm_q[1] <= '0;
      nrm_q[2] <= NormalZReset;
      tag_q    <= '0;
      lim_q    <= LimitReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegOriginX: org_q[0] <= pwdata;
        RegOriginY: org_q[1] <= pwdata;
        RegOriginZ: org_q[2] <= pwdata;
        RegNormalX: nrm_q[0] <= pwdata;
        RegNormalY: nrm_q[1] <= pwdata;
        RegNormalZ: nrm_q[2] <= pwdata;
        RegTag:     tag_q    <= pwdata[7:0];
        RegLimit:   lim_q    <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegOriginX: prdata = org_q[0];
      RegOriginY: prdata = org_q[1];
      RegOriginZ: prdata = org_q[2];
      RegNormalX: prdata = nrm_q[0];
      RegNormalY: prdata = nrm_q[1];
      RegNormalZ: prdata = nrm_q[2];
      RegTag:     prdata = {24'b0, tag_q};
      RegLimit:   prdata = {16'b0, lim_q};
    endcase
  end

  // Valid bits and carried payload.
  logic                     vld_q [StDif:PipeDepth];
  logic signed [CoordW-1:0] vtx_q [StDif:StLrm][3][3];
  tps_ctl_t                 ctl_q [StCls:StNear];

  logic signed [CoordW-1:0] vin [3][3];

  always_comb begin
    vin[0][0] = item_i.a_x;
    vin[0][1] = item_i.a_y;
    vin[0][2] = item_i.a_z;
    vin[1][0] = item_i.b_x;
    vin[1][1] = item_i.b_y;
    vin[1][2] = item_i.b_z;
    vin[2][0] = item_i.c_x;
    vin[2][1] = item_i.c_y;
    vin[2][2] = item_i.c_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = StDif; s <= PipeDepth; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[StDif] <= start && !busy;
      for (int s = StDif + 1; s <= PipeDepth; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // Stage 1: vertex minus origin, exact in 33 bits.
  logic signed [DiffW-1:0] dif_d [3][3];
  logic signed [DiffW-1:0] dif_q [3][3];

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int a = 0; a < 3; a++) begin
        dif_d[v][a] = {vin[v][a][CoordW-1], vin[v][a]} - {org_q[a][CoordW-1], org_q[a]};
      end
    end
  end

  // Stage 2: magnitude products with the normal, truncated by 24 bits.
  logic [DiffW-1:0]  dmag [3][3];
  logic [CoordW-1:0] nmag [3];
  logic [64:0]       prod [3][3];
  logic [TermW-1:0]  trm_d [3][3];
  logic [TermW-1:0]  trm_q [3][3];
  logic              tneg_d [3][3];
  logic              tneg_q [3][3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nmag[a] = nrm_q[a][CoordW-1] ? CoordW'(-nrm_q[a]) : CoordW'(nrm_q[a]);
    end
    for (int v = 0; v < 3; v++) begin
      for (int a = 0; a < 3; a++) begin
        dmag[v][a]   = dif_q[v][a][DiffW-1] ? DiffW'(-dif_q[v][a]) : DiffW'(dif_q[v][a]);
        prod[v][a]   = dmag[v][a] * nmag[a];
        trm_d[v][a]  = prod[v][a][63:24];
        tneg_d[v][a] = dif_q[v][a][DiffW-1] ^ nrm_q[a][CoordW-1];
      end
    end
  end

  // Stage 3: signed distances.
  logic signed [DistW-1:0] term [3][3];
  logic signed [DistW-1:0] dst_d [3];
  logic signed [DistW-1:0] dst_q [3];

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int a = 0; a < 3; a++) begin
        term[v][a] = tneg_q[v][a] ? -$signed({3'b000, trm_q[v][a]})
                                  : $signed({3'b000, trm_q[v][a]});
      end
      dst_d[v] = term[v][0] + term[v][1] + term[v][2];
    end
  end

  // Stage 4: classification, and the dividend and divisor of each edge.
  logic [DistW-1:0] dmg [3];
  logic [2:0]       dneg;
  logic [2:0]       dpos;
  logic [2:0]       le0;
  tps_ctl_t         ctl_d;
  logic [DistW-1:0] am_d [3];
  logic [DistW-1:0] sm_d [3];
  logic [3:0]       nsh_d [3];
  logic [DistW-1:0] am_q [3];
  logic [DistW-1:0] sm_q [3];
  logic [3:0]       nsh_q [3];
  int unsigned      kk;

  always_comb begin
    kk    = 0;
    ctl_d = '0;
    for (int v = 0; v < 3; v++) begin
      dneg[v]     = dst_q[v][DistW-1];
      dpos[v]     = !dneg[v] && (dst_q[v] != '0);
      le0[v]      = !dpos[v];
      dmg[v]      = dneg[v] ? DistW'(-dst_q[v]) : DistW'(dst_q[v]);
      ctl_d.on[v] = dmg[v] < DistW'(lim_q);
    end
    ctl_d.miss = (&dpos) || (&dneg);
    for (int e = 0; e < 3; e++) begin
      kk = (e == 2) ? 0 : e + 1;
      ctl_d.xing[e] = !ctl_d.on[e] && !ctl_d.on[kk] &&
                      ((le0[e] && !dneg[kk]) || (!dneg[e] && le0[kk]));
      am_d[e]  = dmg[e];
      sm_d[e]  = dmg[e] + dmg[kk];
      nsh_d[e] = '0;
      // The highest set bit above the divisor width sets the common shift.
      for (int j = 0; j < ShMax; j++) begin
        if (sm_d[e][SumW+j]) nsh_d[e] = 4'(j + 1);
      end
    end
  end

  // Stage 5 and the divider stages.
  logic [SumW-1:0] drem_d [StNrm:StDivN][3];
  logic [SumW-1:0] dsor_d [StNrm:StDivN][3];
  logic [QuoW-1:0] dquo_d [StDiv0:StDivN][3];
  logic [SumW-1:0] drem_q [StNrm:StDivN][3];
  logic [SumW-1:0] dsor_q [StNrm:StDivN][3];
  logic [QuoW-1:0] dquo_q [StDiv0:StDivN][3];
  logic [DistW-1:0] sh_a [3];
  logic [DistW-1:0] sh_s [3];
  logic [SumW:0]    rsh;
  logic             ge;

  always_comb begin
    rsh = '0;
    ge  = 1'b0;
    for (int e = 0; e < 3; e++) begin
      sh_a[e] = am_q[e] >> nsh_q[e];
      sh_s[e] = sm_q[e] >> nsh_q[e];
      drem_d[StNrm][e] = sh_a[e][SumW-1:0];
      // A zero divisor only comes with a zero dividend; all ones gives t = 0.
      dsor_d[StNrm][e] = (sh_s[e] == '0) ? '1 : sh_s[e][SumW-1:0];
    end
    for (int g = StDiv0; g <= StDivN; g++) begin
      for (int e = 0; e < 3; e++) begin
        dsor_d[g][e] = dsor_q[g-1][e];
        if (g == StDiv0) begin
          ge = drem_q[g-1][e] >= dsor_q[g-1][e];
          drem_d[g][e] = ge ? drem_q[g-1][e] - dsor_q[g-1][e] : drem_q[g-1][e];
          dquo_d[g][e] = QuoW'(ge);
        end else begin
          rsh = {drem_q[g-1][e], 1'b0};
          ge  = rsh >= {1'b0, dsor_q[g-1][e]};
          drem_d[g][e] = ge ? SumW'(rsh - {1'b0, dsor_q[g-1][e]}) : rsh[SumW-1:0];
          dquo_d[g][e] = {dquo_q[g-1][e][QuoW-2:0], ge};
        end
      end
    end
  end

  // Interpolation: magnitude product, then rounding and the add.
  logic signed [DiffW-1:0] ldif [3][3];
  logic [DiffW-1:0]        lmag [3][3];
  logic [63:0]             lprod_d [3][3];
  logic [63:0]             lprod_q [3][3];
  logic                    lneg_d [3][3];
  logic                    lneg_q [3][3];
  logic [63:0]             lrnd [3][3];
  logic signed [SumW:0]    lsum [3][3];
  logic signed [CoordW-1:0] cand_d [NumCand][3];
  logic signed [CoordW-1:0] cand_q [StCnd:StNear][NumCand][3];
  int unsigned              lk;

  always_comb begin
    lk = 0;
    for (int e = 0; e < 3; e++) begin
      lk = (e == 2) ? 0 : e + 1;
      for (int a = 0; a < 3; a++) begin
        ldif[e][a] = {vtx_q[StDivN][lk][a][CoordW-1], vtx_q[StDivN][lk][a]} -
                     {vtx_q[StDivN][e][a][CoordW-1], vtx_q[StDivN][e][a]};
        lmag[e][a] = ldif[e][a][DiffW-1] ? DiffW'(-ldif[e][a]) : DiffW'(ldif[e][a]);
        lprod_d[e][a] = lmag[e][a] * dquo_q[StDivN][e];
        lneg_d[e][a]  = ldif[e][a][DiffW-1];
      end
    end
    for (int e = 0; e < 3; e++) begin
      for (int a = 0; a < 3; a++) begin
        lrnd[e][a] = lprod_q[e][a] + 64'h2000_0000;
        lsum[e][a] = lneg_q[e][a]
          ? $signed({{2{vtx_q[StLrm][e][a][CoordW-1]}}, vtx_q[StLrm][e][a]}) -
            $signed({1'b0, lrnd[e][a][62:30]})
          : $signed({{2{vtx_q[StLrm][e][a][CoordW-1]}}, vtx_q[StLrm][e][a]}) +
            $signed({1'b0, lrnd[e][a][62:30]});
        cand_d[e][a]   = lsum[e][a][CoordW-1:0];
        cand_d[3+e][a] = vtx_q[StLrm][e][a];
      end
    end
  end

  // Duplicate test: per-pair axis distances, then squared sum.
  logic                    far_d [NumCand][NumCand];
  logic                    far_q [NumCand][NumCand];
  logic [15:0]             dlo_d [NumCand][NumCand][3];
  logic [15:0]             dlo_q [NumCand][NumCand][3];
  logic                    near_d [NumCand][NumCand];
  logic                    near_q [NumCand][NumCand];
  logic signed [DiffW-1:0] pdif;
  logic [DiffW-1:0]        pmag;
  logic [SumW:0]           ssum;

  always_comb begin
    pdif = '0;
    pmag = '0;
    ssum = '0;
    for (int j = 0; j < NumCand; j++) begin
      for (int i = 0; i < NumCand; i++) begin
        far_d[j][i]  = 1'b0;
        near_d[j][i] = 1'b0;
        for (int a = 0; a < 3; a++) dlo_d[j][i][a] = '0;
      end
    end
    for (int j = 1; j < NumCand; j++) begin
      for (int i = 0; i < j; i++) begin
        for (int a = 0; a < 3; a++) begin
          pdif = {cand_q[StCnd][j][a][CoordW-1], cand_q[StCnd][j][a]} -
                 {cand_q[StCnd][i][a][CoordW-1], cand_q[StCnd][i][a]};
          pmag = pdif[DiffW-1] ? DiffW'(-pdif) : DiffW'(pdif);
          if (pmag[DiffW-1:16] != '0) far_d[j][i] = 1'b1;
          dlo_d[j][i][a] = pmag[15:0];
        end
        ssum = (SumW+1)'(dlo_q[j][i][0] * dlo_q[j][i][0]) +
               (SumW+1)'(dlo_q[j][i][1] * dlo_q[j][i][1]) +
               (SumW+1)'(dlo_q[j][i][2] * dlo_q[j][i][2]);
        near_d[j][i] = !far_q[j][i] && (ssum < (SumW+1)'(DupLimit));
      end
    end
  end

  // Last stage: keep the survivors in order and form the segment.
  logic [NumCand-1:0]       pres;
  logic [NumCand-1:0]       kept;
  logic                     dup;
  logic [1:0]               nk;
  logic signed [CoordW-1:0] p0 [3];
  logic signed [CoordW-1:0] p1 [3];
  logic signed [DiffW-1:0]  nsum;
  tps_result_t              res_d;
  tps_result_t              res_q;

  always_comb begin
    pres = {ctl_q[StNear].on, ctl_q[StNear].xing};
    kept = '0;
    dup  = 1'b0;
    nk   = '0;
    nsum = '0;
    for (int a = 0; a < 3; a++) begin
      p0[a] = '0;
      p1[a] = '0;
    end
    for (int j = 0; j < NumCand; j++) begin
      dup = 1'b0;
      for (int i = 0; i < j; i++) begin
        if (kept[i] && near_q[j][i]) dup = 1'b1;
      end
      kept[j] = pres[j] && !dup;
      if (kept[j]) begin
        for (int a = 0; a < 3; a++) begin
          if (nk == 2'd0) p0[a] = cand_q[StNear][j][a];
          if (nk == 2'd1) p1[a] = cand_q[StNear][j][a];
        end
        if (nk != 2'd2) nk = nk + 2'd1;
      end
    end
    // A lone survivor is nudged along every axis, clipping at the top.
    if (nk == 2'd1) begin
      for (int a = 0; a < 3; a++) begin
        nsum  = {p0[a][CoordW-1], p0[a]} + Nudge;
        p1[a] = (nsum[DiffW-1:DiffW-2] == 2'b01) ? {1'b0, {(CoordW-1){1'b1}}}
                                                 : nsum[CoordW-1:0];
      end
    end
    res_d = '0;
    if (!ctl_q[StNear].miss && nk != 2'd0) begin
      res_d.hit     = 1'b1;
      res_d.start_x = p0[0];
      res_d.start_y = p0[1];
      res_d.start_z = p0[2];
      res_d.end_x   = p1[0];
      res_d.end_y   = p1[1];
      res_d.end_z   = p1[2];
      res_d.tag_out = tag_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    vtx_q[StDif] <= vin;
    for (int s = StDif + 1; s <= StLrm; s++) vtx_q[s] <= vtx_q[s-1];
    dif_q  <= dif_d;
    trm_q  <= trm_d;
    tneg_q <= tneg_d;
    dst_q  <= dst_d;
    ctl_q[StCls] <= ctl_d;
    for (int s = StCls + 1; s <= StNear; s++) ctl_q[s] <= ctl_q[s-1];
    am_q   <= am_d;
    sm_q   <= sm_d;
    nsh_q  <= nsh_d;
    drem_q <= drem_d;
    dsor_q <= dsor_d;
    dquo_q <= dquo_d;
    lprod_q <= lprod_d;
    lneg_q  <= lneg_d;
    cand_q[StCnd] <= cand_d;
    for (int s = StCnd + 1; s <= StNear; s++) cand_q[s] <= cand_q[s-1];
    far_q  <= far_d;
    dlo_q  <= dlo_d;
    near_q <= near_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (vld_q[StNear]) begin
      res_q <= res_d;
    end
  end

  assign done_o = vld_q[PipeDepth];
  assign res_o  = res_q;

endmodule
`default_nettype wire

// File: hdl/tps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_plane_slice_core_assert.svh"
module tps_checker
  import tps_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire tps_result_t res_o
);

  // A result beat only ever follows a taken triangle by the pipeline depth.
  `TPS_ASSERT_IMP(a_done_has_item, clk_i, rst_ni, done_o, $past(start && !busy, PipeDepth), "result beat without a matching input beat")

  `TPS_ASSERT_IMP(a_miss_is_zero, clk_i, rst_ni, done_o && !res_o.hit, res_o == '0, "miss result carries non-zero fields")

  // Equal ends are only possible when the nudge clipped on every axis.
  `TPS_ASSERT_IMP(a_equal_ends, clk_i, rst_ni, done_o && res_o.hit && res_o.start_x == res_o.end_x && res_o.start_y == res_o.end_y && res_o.start_z == res_o.end_z, res_o.start_x == 32'sh7fffffff && res_o.start_y == 32'sh7fffffff && res_o.start_z == 32'sh7fffffff, "segment ends coincide")

  `TPS_ASSERT_NEXT(a_res_held, clk_i, rst_ni, 1'b1, done_o || $stable(res_o), "result changed without a beat")

endmodule

bind triangle_plane_slice_core tps_checker u_tps_checker (.*);
`default_nettype wire

// File: dv/triangle_plane_slice_core_tb.sv
`timescale 1ns / 1ps
module triangle_plane_slice_core_tb;
  import tps_pkg::*;

  localparam int unsigned Latency = 41;

  // Plane settings as the slicer holds them, with the same reset values.
  typedef struct {
    longint org[3];
    longint nrm[3];
    logic [7:0] tag;
    longint unsigned limit;
  } plane_cfg_t;

  class slice_scoreboard;
    tps_result_t pending[$];
    int errors;

    function void note_triangle(tps_result_t exp_res);
      pending.insert(pending.size(), exp_res);
    endfunction

    task check_segment(tps_result_t got);
      tps_result_t exp_res;
      if (pending.size() == 0) begin
        report_mismatch("result beat with nothing pending");
        return;
      end
      exp_res = pending.pop_front();
      if (got.hit !== exp_res.hit) report_field("hit", got.hit, exp_res.hit);
      if (got.start_x !== exp_res.start_x) report_field("start_x", got.start_x, exp_res.start_x);
      if (got.start_y !== exp_res.start_y) report_field("start_y", got.start_y, exp_res.start_y);
      if (got.start_z !== exp_res.start_z) report_field("start_z", got.start_z, exp_res.start_z);
      if (got.end_x !== exp_res.end_x) report_field("end_x", got.end_x, exp_res.end_x);
      if (got.end_y !== exp_res.end_y) report_field("end_y", got.end_y, exp_res.end_y);
      if (got.end_z !== exp_res.end_z) report_field("end_z", got.end_z, exp_res.end_z);
      if (got.tag_out !== exp_res.tag_out) report_field("tag_out", got.tag_out, exp_res.tag_out);
    endtask

    task report_field(string name, logic [31:0] got, logic [31:0] want);
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  tps_item_t item_i = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic busy, done_o, pready;
  tps_result_t res_o;
  logic [DataW-1:0] prdata;

  plane_cfg_t plane;
  slice_scoreboard sb;
  int sent_count;

  always #5 clk_i = ~clk_i;

  triangle_plane_slice_core i_dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .done_o, .res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // Product shifted right by 24 with the magnitude truncated.
  function automatic longint scaled_product(longint d, longint n);
    longint unsigned m, k, r;
    m = magn(d);
    k = magn(n);
    r = (m >> 24) * k + (((m & 64'hFF_FFFF) * k) >> 24);
    return ((d < 0) != (n < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint lerp_coord(longint a, longint b, longint unsigned t);
    longint d;
    longint unsigned m;
    d = b - a;
    m = (magn(d) * t + (64'd1 << 29)) >> 30;
    return d < 0 ? a - longint'(m) : a + longint'(m);
  endfunction

  function automatic tps_result_t slice_triangle(tps_item_t it);
    longint v[3][3], cand[6][3], kept[6][3], d[3];
    bit on[3], opp, dup;
    int nc, nk, k;
    longint unsigned a, s, t, dx, dy, dz;
    tps_result_t r;
    nc = 0;
    nk = 0;
    r = '0;
    v[0] = '{it.a_x, it.a_y, it.a_z};
    v[1] = '{it.b_x, it.b_y, it.b_z};
    v[2] = '{it.c_x, it.c_y, it.c_z};
    for (int i = 0; i < 3; i++) begin
      d[i] = 0;
      for (int ax = 0; ax < 3; ax++) d[i] += scaled_product(v[i][ax] - plane.org[ax], plane.nrm[ax]);
      on[i] = magn(d[i]) < plane.limit;
    end
    if ((d[0] > 0 && d[1] > 0 && d[2] > 0) || (d[0] < 0 && d[1] < 0 && d[2] < 0)) return r;
    for (int i = 0; i < 3; i++) begin
      k = (i + 1) % 3;
      opp = (d[i] <= 0 && d[k] >= 0) || (d[i] >= 0 && d[k] <= 0);
      if (!on[i] && !on[k] && opp) begin
        a = magn(d[i]);
        s = magn(d[i]) + magn(d[k]);
        t = 0;
        while (s >= 64'h2_0000_0000) begin
          a >>= 1;
          s >>= 1;
        end
        if (s != 0) t = (a << 30) / s;
        for (int ax = 0; ax < 3; ax++) cand[nc][ax] = lerp_coord(v[i][ax], v[k][ax], t);
        nc++;
      end
    end
    for (int i = 0; i < 3; i++) if (on[i]) begin
      cand[nc] = v[i];
      nc++;
    end
    for (int i = 0; i < nc; i++) begin
      dup = 0;
      for (int j = 0; j < nk; j++) begin
        dx = magn(cand[i][0] - kept[j][0]);
        dy = magn(cand[i][1] - kept[j][1]);
        dz = magn(cand[i][2] - kept[j][2]);
        if (dx < 65536 && dy < 65536 && dz < 65536 && dx*dx + dy*dy + dz*dz < DupLimit) dup = 1;
      end
      if (!dup) begin
        kept[nk] = cand[i];
        nk++;
      end
    end
    if (nk == 0) return r;
    r.hit = 1'b1;
    r.start_x = 32'(kept[0][0]);
    r.start_y = 32'(kept[0][1]);
    r.start_z = 32'(kept[0][2]);
    if (nk >= 2) begin
      r.end_x = 32'(kept[1][0]);
      r.end_y = 32'(kept[1][1]);
      r.end_z = 32'(kept[1][2]);
    end else begin
      r.end_x = 32'((kept[0][0] + 1678 > 2147483647) ? 2147483647 : kept[0][0] + 1678);
      r.end_y = 32'((kept[0][1] + 1678 > 2147483647) ? 2147483647 : kept[0][1] + 1678);
      r.end_z = 32'((kept[0][2] + 1678 > 2147483647) ? 2147483647 : kept[0][2] + 1678);
    end
    r.tag_out = plane.tag;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_segment(res_o);
  end

  task automatic write_reg(tps_reg_e idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegOriginX: plane.org[0] = longint'(signed'(value));
      RegOriginY: plane.org[1] = longint'(signed'(value));
      RegOriginZ: plane.org[2] = longint'(signed'(value));
      RegNormalX: plane.nrm[0] = longint'(signed'(value));
      RegNormalY: plane.nrm[1] = longint'(signed'(value));
      RegNormalZ: plane.nrm[2] = longint'(signed'(value));
      RegTag:     plane.tag = value[7:0];
      RegLimit:   plane.limit = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_plane(logic [31:0] ox, oy, oz, nx, ny, nz, logic [7:0] tag,
                           logic [15:0] lim);
    write_reg(RegOriginX, ox);
    write_reg(RegOriginY, oy);
    write_reg(RegOriginZ, oz);
    write_reg(RegNormalX, nx);
    write_reg(RegNormalY, ny);
    write_reg(RegNormalZ, nz);
    write_reg(RegTag, {24'd0, tag});
    write_reg(RegLimit, {16'd0, lim});
  endtask

  // Holds start for one beat; the caller decides about gaps.
  task automatic send_triangle(tps_item_t it, bit gappy);
    if (gappy) while ($urandom_range(99) < 15) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note_triangle(slice_triangle(it));
    sent_count++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
    endcase
  endfunction

  // Mostly triangles near the plane so that they straddle it; some fully random.
  function automatic tps_item_t rnd_triangle(int mode);
    tps_item_t it;
    it.a_x = rnd_coord(mode); it.a_y = rnd_coord(mode); it.a_z = rnd_coord(mode);
    it.b_x = rnd_coord(mode); it.b_y = rnd_coord(mode); it.b_z = rnd_coord(mode);
    it.c_x = rnd_coord(mode); it.c_y = rnd_coord(mode); it.c_z = rnd_coord(mode);
    if ($urandom_range(3) == 0) it.b_z = it.a_z;
    if ($urandom_range(5) == 0) begin
      it.c_x = it.a_x;
      it.c_y = it.a_y;
      it.c_z = it.a_z;
    end
    return it;
  endfunction

  function automatic tps_item_t tri9(logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz);
    return '{ax, ay, az, bx, by, bz, cx, cy, cz};
  endfunction

  task automatic random_phase(int count, int mode, bit gappy);
    for (int n = 0; n < count; n++) send_triangle(rnd_triangle(mode), gappy);
  endtask

  localparam logic [31:0] One = 32'h0100_0000;
  localparam logic [31:0] MaxC = 32'h7FFF_FFFF;
  localparam logic [31:0] MinC = 32'h8000_0000;

  initial begin
    sb = new();
    plane.org = '{0, 0, 0};
    plane.nrm = '{0, 0, 16777216};
    plane.tag = 8'd0;
    plane.limit = 17;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats against the reset plane z = 0.
    send_triangle(tri9(0, 0, One, One, 0, One, 0, One, 32'h0200_0000), 0);   // all above
    send_triangle(tri9(0, 0, -One, One, 0, -One, 0, One, -One), 0);          // all below
    send_triangle(tri9(0, 0, -One, One, 0, One, 0, One, One), 0);            // two crossings
    send_triangle(tri9(0, 0, 0, One, 0, One, 0, One, -One), 0);              // vertex on plane
    send_triangle(tri9(0, 0, 0, One, 0, 0, 0, One, One), 0);                 // edge on plane
    send_triangle(tri9(5, 5, 0, 5, 5, 0, 5, 5, One), 0);                     // duplicate points
    send_triangle(tri9(MaxC, MaxC, 0, MaxC, 0, One, 0, MaxC, One), 0);       // single, saturating
    send_triangle(tri9(MinC, MinC, MinC, MaxC, MaxC, MaxC, 0, 0, MaxC), 0);  // extremes
    send_triangle(tri9(MaxC, MinC, MaxC, MinC, MaxC, MinC, MaxC, MaxC, 1), 0);
    send_triangle(tri9(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    drain();

    // Zero normal: every distance is zero.
    set_plane(0, 0, 0, 0, 0, 0, 8'hFF, 16'hFFFF);
    send_triangle(tri9(0, 0, 0, One, 0, 0, 0, One, 0), 0);
    send_triangle(tri9(MaxC, MinC, 0, 0, 0, 0, 1, 1, 1), 0);
    drain();
    // Limit zero: both ends of an edge can sit exactly on the plane.
    set_plane(MinC, MaxC, 0, One, 0, 0, 8'h5A, 16'h0000);
    send_triangle(tri9(MinC, 0, 0, MinC, One, 0, MinC + One, 0, 0), 0);
    send_triangle(tri9(MinC, 0, 0, MinC, One, 0, MinC - 1, 0, One), 0);
    drain();
    // Extreme normal with large distances exercises the sum shift.
    set_plane(MaxC, MinC, MaxC, MinC, MaxC, MinC, 8'hA5, 16'hFFFF);
    send_triangle(tri9(MinC, MaxC, MinC, MaxC, MinC, MaxC, 0, 0, 0), 0);
    send_triangle(tri9(MaxC, MinC, MaxC, MinC, MaxC, MinC, MinC, MaxC, MinC), 0);
    drain();

    // Random phases over several planes; in one of them the near-plane triangles go with no gaps.
    for (int ph = 0; ph < 8; ph++) begin
      set_plane(rnd_coord(2), rnd_coord(2), rnd_coord(2),
                (ph % 3 == 0) ? $urandom() : rnd_coord(1), rnd_coord(1), rnd_coord(1),
                8'($urandom_range(255)),
                (ph == 5) ? 16'hFFFF : 16'($urandom_range(0, 4096)));
      random_phase(110, 2, ph != 3);
      random_phase(30, 1, 1);
      random_phase(15, 0, 1);
      drain();
    end
    finish_run();
  end

  task automatic finish_run();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  endtask

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
